// ===== sv/remote_pulse_distance_encoder_macros.svh =====
// assertion helpers for the checker file
`ifndef REMOTE_PULSE_DISTANCE_ENCODER_MACROS_SVH
`define REMOTE_PULSE_DISTANCE_ENCODER_MACROS_SVH

// clocked check, switched off while reset is held
`define RPDE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RPDE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rpde_pkg.sv =====
`default_nettype none
package rpde_pkg;

	localparam int DATA_BITS              = 7;
	localparam int REPEATED_COMMAND_SENDS = 1;
	localparam int FRAME_LEN              = 2 * DATA_BITS + 3;
	localparam int POS_W                  = $clog2(FRAME_LEN + 1);
	localparam int TIME_W                 = 18;
	localparam int CMD_W                  = 7;
	localparam int SENDS_W                = 3;
	localparam int CFG_IDX_W              = 3;
	localparam int CFG_DATA_W             = 18;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_PULSE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_PAUSE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_CMD    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_SENDS   = 3'd7;

	localparam logic [15:0]         RST_BIT_TIME   = 16'd530;
	localparam logic [15:0]         RST_LEAD_PULSE = 16'd9000;
	localparam logic [15:0]         RST_LEAD_PAUSE = 16'd4000;
	localparam logic [15:0]         RST_FRAME_GAP  = 16'd16000;
	localparam logic [17:0]         RST_HOLD_DELAY = 18'd175000;
	localparam logic [CMD_W-1:0]    RST_HOLD_CMD   = 7'h04;
	localparam logic [CMD_W-1:0]    RST_DEV_ADDR   = 7'h47;
	localparam logic [SENDS_W-1:0]  RST_NEW_SENDS  = 3'd3;
	localparam logic [CMD_W:0]      LAST_CMD_NONE  = 8'd255;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_PAUSE,
		PH_BIT_ON,
		PH_BIT_OFF,
		PH_GAP,
		PH_HOLD
	} phase_t;

	typedef struct packed {
		logic [15:0]        bit_time;
		logic [15:0]        lead_pulse;
		logic [15:0]        lead_pause;
		logic [15:0]        frame_gap;
		logic [17:0]        hold_delay;
		logic [CMD_W-1:0]   hold_command;
		logic [CMD_W-1:0]   device_address;
		logic [SENDS_W-1:0] new_command_sends;
	} cfg_t;

	typedef struct packed {
		phase_t               phase;
		logic [TIME_W-1:0]    time_left;
		logic [POS_W-1:0]     bit_position;
		logic [FRAME_LEN-1:0] frame_bits;
		logic [SENDS_W-1:0]   sends_left;
		logic [CMD_W-1:0]     current_command;
		logic [CMD_W:0]       last_command;
	} enc_state_t;

	typedef struct packed {
		logic line_active;
		logic busy_res;
		logic accepted;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/rpde_next.sv =====
`default_nettype none
module rpde_next (
	input  var rpde_pkg::enc_state_t  cur,
	input  var rpde_pkg::cfg_t        cfg,
	input  wire                       opcode,
	input  wire [rpde_pkg::CMD_W-1:0] command,
	output rpde_pkg::enc_state_t      nxt,
	output rpde_pkg::res_t            res
);

	typedef enum logic [1:0] {ST_LEAD, ST_PAUSE, ST_BIT, ST_GAP} stage_t;

	// any segment of nonzero length left in the frame from this stage on
	function automatic logic found(rpde_pkg::cfg_t c, stage_t start);
		logic f;
		case (start)
			ST_LEAD:  f = (c.lead_pulse != '0) || (c.lead_pause != '0) ||
				(c.bit_time != '0) || (c.frame_gap != '0);
			ST_PAUSE: f = (c.lead_pause != '0) || (c.bit_time != '0) || (c.frame_gap != '0);
			ST_BIT:   f = (c.bit_time != '0) || (c.frame_gap != '0);
			ST_GAP:   f = (c.frame_gap != '0);
			default:  f = 1'b0;
		endcase
		return f;
	endfunction

	// first nonzero segment at or after start
	function automatic rpde_pkg::enc_state_t pick(rpde_pkg::enc_state_t s, rpde_pkg::cfg_t c,
			stage_t start);
		rpde_pkg::enc_state_t n;
		n = s;
		if (start == ST_LEAD && c.lead_pulse != '0) begin
			n.phase     = rpde_pkg::PH_LEAD;
			n.time_left = rpde_pkg::TIME_W'(c.lead_pulse);
		end else if (start <= ST_PAUSE && c.lead_pause != '0) begin
			n.phase     = rpde_pkg::PH_PAUSE;
			n.time_left = rpde_pkg::TIME_W'(c.lead_pause);
		end else if (start <= ST_BIT && c.bit_time != '0) begin
			n.phase        = rpde_pkg::PH_BIT_ON;
			n.bit_position = '0;
			n.time_left    = rpde_pkg::TIME_W'(c.bit_time);
		end else if (c.frame_gap != '0) begin
			n.phase        = rpde_pkg::PH_GAP;
			n.bit_position = rpde_pkg::POS_W'(rpde_pkg::FRAME_LEN);
			n.time_left    = rpde_pkg::TIME_W'(c.frame_gap);
		end else begin
			n.phase     = rpde_pkg::PH_IDLE;
			n.time_left = '0;
		end
		return n;
	endfunction

	// end of a frame: next frame, hold delay or idle; empty frames all collapse
	function automatic rpde_pkg::enc_state_t after_frame(rpde_pkg::enc_state_t s,
			rpde_pkg::cfg_t c);
		rpde_pkg::enc_state_t n;
		n = s;
		n.sends_left = (s.sends_left != '0) ? s.sends_left - 1'b1 : '0;
		if (n.sends_left != '0 && found(c, ST_LEAD)) begin
			n = pick(n, c, ST_LEAD);
		end else begin
			n.sends_left = '0;
			if (s.current_command == c.hold_command && c.hold_delay != '0) begin
				n.phase     = rpde_pkg::PH_HOLD;
				n.time_left = c.hold_delay;
			end else begin
				n.phase     = rpde_pkg::PH_IDLE;
				n.time_left = '0;
			end
		end
		return n;
	endfunction

	function automatic rpde_pkg::enc_state_t from_stage(rpde_pkg::enc_state_t s,
			rpde_pkg::cfg_t c, stage_t start);
		rpde_pkg::enc_state_t n;
		if (found(c, start))
			n = pick(s, c, start);
		else
			n = after_frame(s, c);
		return n;
	endfunction

	logic                      seg_end;
	logic                      cur_bit;
	logic [rpde_pkg::TIME_W-1:0] off_time;
	logic [rpde_pkg::POS_W-1:0]  pos_inc;
	logic [rpde_pkg::SENDS_W-1:0] sends_new;
	rpde_pkg::enc_state_t      base;

	assign seg_end = (cur.time_left <= rpde_pkg::TIME_W'(1));
	assign cur_bit = (cur.bit_position < rpde_pkg::POS_W'(rpde_pkg::FRAME_LEN)) ?
		cur.frame_bits[cur.bit_position] : 1'b0;
	assign off_time = cur_bit ?
		rpde_pkg::TIME_W'({cfg.bit_time, 1'b0}) + rpde_pkg::TIME_W'(cfg.bit_time) :
		rpde_pkg::TIME_W'(cfg.bit_time);
	assign pos_inc = cur.bit_position + 1'b1;
	assign sends_new = ({1'b0, command} == cur.last_command) ?
		rpde_pkg::SENDS_W'(rpde_pkg::REPEATED_COMMAND_SENDS) :
		((cfg.new_command_sends == '0) ? rpde_pkg::SENDS_W'(1) : cfg.new_command_sends);

	// next state
	always_comb begin
		nxt  = cur;
		base = cur;
		if (opcode) begin
			if (cur.phase == rpde_pkg::PH_IDLE) begin
				base.last_command    = {1'b0, command};
				base.current_command = command;
				base.sends_left      = sends_new;
				base.frame_bits      = '0;
				base.frame_bits[0]   = 1'b1;
				base.frame_bits[rpde_pkg::DATA_BITS:1] =
					rpde_pkg::DATA_BITS'(cfg.device_address);
				base.frame_bits[2*rpde_pkg::DATA_BITS:rpde_pkg::DATA_BITS+1] =
					rpde_pkg::DATA_BITS'(command);
				base.frame_bits[rpde_pkg::FRAME_LEN-1 -: 2] = 2'b11;
				base.bit_position    = '0;
				nxt = from_stage(base, cfg, ST_LEAD);
			end
		end else if (cur.phase != rpde_pkg::PH_IDLE) begin
			if (!seg_end) begin
				nxt.time_left = cur.time_left - 1'b1;
			end else begin
				case (cur.phase)
					rpde_pkg::PH_LEAD:  nxt = from_stage(cur, cfg, ST_PAUSE);
					rpde_pkg::PH_PAUSE: nxt = from_stage(cur, cfg, ST_BIT);
					rpde_pkg::PH_BIT_ON: begin
						if (off_time != '0) begin
							nxt.phase     = rpde_pkg::PH_BIT_OFF;
							nxt.time_left = off_time;
						end else if (pos_inc < rpde_pkg::POS_W'(rpde_pkg::FRAME_LEN) &&
								cfg.bit_time != '0) begin
							nxt.phase        = rpde_pkg::PH_BIT_ON;
							nxt.bit_position = pos_inc;
							nxt.time_left    = rpde_pkg::TIME_W'(cfg.bit_time);
						end else begin
							nxt = from_stage(cur, cfg, ST_GAP);
						end
					end
					rpde_pkg::PH_BIT_OFF: begin
						// a zero bit time skips every remaining bit
						if (pos_inc < rpde_pkg::POS_W'(rpde_pkg::FRAME_LEN) &&
								cfg.bit_time != '0) begin
							nxt.phase        = rpde_pkg::PH_BIT_ON;
							nxt.bit_position = pos_inc;
							nxt.time_left    = rpde_pkg::TIME_W'(cfg.bit_time);
						end else begin
							base.bit_position = pos_inc;
							nxt = from_stage(base, cfg, ST_GAP);
						end
					end
					rpde_pkg::PH_GAP: nxt = after_frame(cur, cfg);
					default: begin
						nxt.phase     = rpde_pkg::PH_IDLE;
						nxt.time_left = '0;
					end
				endcase
			end
		end
	end

	// result word: a tick reports the microsecond now passing, a request the one after it
	always_comb begin
		res.accepted = opcode && (cur.phase == rpde_pkg::PH_IDLE);
		if (opcode) begin
			res.line_active = (nxt.phase == rpde_pkg::PH_LEAD) ||
				(nxt.phase == rpde_pkg::PH_BIT_ON);
			res.busy_res    = (nxt.phase != rpde_pkg::PH_IDLE);
		end else begin
			res.line_active = (cur.phase == rpde_pkg::PH_LEAD) ||
				(cur.phase == rpde_pkg::PH_BIT_ON);
			res.busy_res    = (cur.phase != rpde_pkg::PH_IDLE);
		end
	end

endmodule
`default_nettype wire

// ===== sv/remote_pulse_distance_encoder.sv =====
// an accepted input word is held in the input register, then its result word in the result register
// throughput: one word per cycle while the result side is not stalled, set by the combinational state
// update between the input register and the result register
// reset: arst_n clears control state asynchronously and restores the register
// defaults; the line is idle and no command has been sent yet
`default_nettype none
module remote_pulse_distance_encoder (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [7:0]                           s_tdata,   // [6:0] command
	input  wire                                 s_tuser,   // [0] opcode
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [7:0]                          m_tdata,   // [0] line_active, [1] busy_res, [2] accepted
	input  wire                                 cfg_we,
	input  wire [rpde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [rpde_pkg::CFG_DATA_W-1:0]      cfg_data
);

	rpde_pkg::cfg_t       cfg_q;
	rpde_pkg::enc_state_t state_q;
	rpde_pkg::enc_state_t state_nxt;
	rpde_pkg::res_t       res;

	logic                         valid_s1;
	logic                         opcode_s1;
	logic [rpde_pkg::CMD_W-1:0]   command_s1;
	logic                         advance;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_time          <= rpde_pkg::RST_BIT_TIME;
			cfg_q.lead_pulse        <= rpde_pkg::RST_LEAD_PULSE;
			cfg_q.lead_pause        <= rpde_pkg::RST_LEAD_PAUSE;
			cfg_q.frame_gap         <= rpde_pkg::RST_FRAME_GAP;
			cfg_q.hold_delay        <= rpde_pkg::RST_HOLD_DELAY;
			cfg_q.hold_command      <= rpde_pkg::RST_HOLD_CMD;
			cfg_q.device_address    <= rpde_pkg::RST_DEV_ADDR;
			cfg_q.new_command_sends <= rpde_pkg::RST_NEW_SENDS;
		end else if (cfg_we) begin
			case (cfg_index)
				rpde_pkg::REG_BIT_TIME:   cfg_q.bit_time   <= cfg_data[15:0];
				rpde_pkg::REG_LEAD_PULSE: cfg_q.lead_pulse <= cfg_data[15:0];
				rpde_pkg::REG_LEAD_PAUSE: cfg_q.lead_pause <= cfg_data[15:0];
				rpde_pkg::REG_FRAME_GAP:  cfg_q.frame_gap  <= cfg_data[15:0];
				rpde_pkg::REG_HOLD_DELAY: cfg_q.hold_delay <= cfg_data[17:0];
				rpde_pkg::REG_HOLD_CMD:   cfg_q.hold_command <= cfg_data[rpde_pkg::CMD_W-1:0];
				rpde_pkg::REG_DEV_ADDR:   cfg_q.device_address <= cfg_data[rpde_pkg::CMD_W-1:0];
				rpde_pkg::REG_NEW_SENDS:
					cfg_q.new_command_sends <= cfg_data[rpde_pkg::SENDS_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1  <= s_tuser;
			command_s1 <= s_tdata[rpde_pkg::CMD_W-1:0];
		end
	end

	rpde_next u_next (
		.cur     (state_q),
		.cfg     (cfg_q),
		.opcode  (opcode_s1),
		.command (command_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= rpde_pkg::PH_IDLE;
			state_q.time_left       <= '0;
			state_q.bit_position    <= '0;
			state_q.frame_bits      <= '0;
			state_q.sends_left      <= '0;
			state_q.current_command <= '0;
			state_q.last_command    <= rpde_pkg::LAST_CMD_NONE;
			m_tvalid                <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			m_tdata <= {5'b0, res.accepted, res.busy_res, res.line_active};
	end

endmodule
`default_nettype wire

// ===== sv/rpde_chk.sv =====
`default_nettype none
`include "remote_pulse_distance_encoder_macros.svh"
module rpde_chk (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_tvalid,
	input wire                                 s_tready,
	input wire [7:0]                           s_tdata,
	input wire                                 s_tuser,
	input wire                                 m_tvalid,
	input wire                                 m_tready,
	input wire [7:0]                           m_tdata,
	input wire                                 cfg_we,
	input wire [rpde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input wire [rpde_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic unused_ok;
	assign unused_ok = s_tvalid ^ s_tready ^ (^s_tdata) ^ s_tuser ^ cfg_we ^
		(^cfg_index) ^ (^cfg_data);

	// no result word may survive reset
	`RPDE_ASSERT_RST(a_rst_no_word, !arst_n |=> !m_tvalid, "result word valid in reset")

	// padding bits of the result word stay clear
	`RPDE_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[7:3] == '0, "result word padding set")

	// the line is only driven inside a frame
	`RPDE_ASSERT(a_line_busy, m_tvalid && m_tdata[0] |-> m_tdata[1],
		"line active while idle")

	`RPDE_ASSERT(a_hold_word, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
		"stalled result word changed")

endmodule

bind remote_pulse_distance_encoder rpde_chk u_rpde_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
`default_nettype wire
